// ----- src/cma_pkg.sv -----
// Shared types and constants for the centered moving average unit.
package cma_pkg;

    localparam int DATA_W = 16;
    localparam int CFG_W  = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } cma_state_t;

endpackage

// ----- src/cma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/cma_div.sv -----
// Restoring divider, one quotient bit per cycle.
module cma_div #(
    parameter int DW = 22,
    parameter int VW = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DW-1:0]         dividend,
    input  logic [VW-1:0]         divisor,
    output logic                  done,
    output logic [DW-1:0]         quotient,
    output logic [VW-1:0]         remainder
);

    localparam int CW = $clog2(DW + 1);

    logic          run_reg, run_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [VW:0]   shifted;
    logic          ge;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign ge      = (shifted >= {1'b0, dvs_reg});
    assign done    = run_reg && (cnt_reg == '0);

    always_comb begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (start) begin
            run_next = 1'b1;
            cnt_next = CW'(DW);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end else if (run_reg) begin
            if (cnt_reg == '0) begin
                run_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 1'b1;
                quo_next = {quo_reg[DW-2:0], ge};
                rem_next = ge ? VW'(shifted - {1'b0, dvs_reg}) : shifted[VW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- src/centered_moving_average_unit.sv -----
// Centered moving average unit: sample ring in RAM, running sum, iterative divider.
// Flow: an accepted input word passes through the ring read, the sum update, a bit-serial
// divide (one divider step per sum bit) when the window is full, and the result capture.
// Input words are taken only in the idle state, so a new word waits until the bit-serial
// divide and every result of the previous word are through; the divider dominates this.
// Reset: synchronous active-low aresetn; window length returns to 1, frame state clears.
module centered_moving_average_unit #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [cma_pkg::CFG_W-1:0]    cfg_window_length,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [cma_pkg::DATA_W-1:0]   s_sample,
    input  logic                         s_frame_end,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [cma_pkg::DATA_W-1:0]   m_smoothed,
    output logic                         m_last_out,
    output logic                         m_short_frame
);

    import cma_pkg::*;

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + PTR_W;
    localparam int EW    = CNT_W + 1;

    cma_state_t state_reg, state_next;

    logic [CFG_W-1:0]       wlen_reg;
    logic [PTR_W-1:0]       ptr_reg;
    logic [CNT_W-1:0]       filled_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic                   fe_reg;
    logic                   full_reg;
    logic                   short_reg;
    logic                   mid_reg;
    logic [CNT_W-1:0]       head_reg;
    logic [CNT_W-1:0]       total_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic [SAMPLE_BITS-1:0] fl_reg;
    logic [SAMPLE_BITS-1:0] rnd_reg;
    logic                   m_valid_reg;
    logic [DATA_W-1:0]      m_smoothed_reg;
    logic                   m_last_reg;
    logic                   m_short_reg;

    logic [CNT_W-1:0]       n_eff;
    logic [CNT_W-1:0]       half;
    logic [PTR_W-1:0]       ev_addr;
    logic [EW-1:0]          ptr_e;
    logic [EW-1:0]          n_e;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic [SAMPLE_BITS-1:0] evict;
    logic [SUM_W-1:0]       sum_upd;
    logic [CNT_W-1:0]       filled_upd;
    logic                   first_win;
    logic                   under;
    logic [CNT_W-1:0]       head_cnt;
    logic [CNT_W-1:0]       total_cnt;
    logic [SUM_W-1:0]       div_q;
    logic [CNT_W-1:0]       div_r;
    logic [SAMPLE_BITS-1:0] emit_val;
    logic                   emit_last;

    logic in_acc;
    logic ram_we;
    logic div_start;
    logic div_done;
    logic emit_fire;
    logic emit_done;

    // effective window length, clamped
    always_comb begin
        if (wlen_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (wlen_reg > CFG_W'(MAX_WINDOW)) begin
            n_eff = CNT_W'(MAX_WINDOW);
        end else begin
            n_eff = CNT_W'(wlen_reg);
        end
    end
    assign half = n_eff >> 1;

    assign ptr_e   = EW'(ptr_reg);
    assign n_e     = EW'(n_eff);
    assign ev_addr = (ptr_e >= n_e) ? PTR_W'(ptr_e - n_e)
                                    : PTR_W'(ptr_e + EW'(MAX_WINDOW) - n_e);

    cma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (smp_reg),
        .re    (in_acc),
        .raddr (ev_addr),
        .rdata (ram_rdata)
    );

    assign evict      = full_reg ? ram_rdata : '0;
    assign sum_upd    = sum_reg - SUM_W'(evict) + SUM_W'(smp_reg);
    assign filled_upd = full_reg ? filled_reg : filled_reg + 1'b1;
    assign first_win  = !full_reg && (filled_upd == n_eff);
    assign under      = filled_upd < n_eff;
    assign head_cnt   = first_win ? half : '0;
    assign total_cnt  = head_cnt + CNT_W'(!fe_reg || n_eff[0]) + (fe_reg ? half : '0);

    cma_div #(
        .DW (SUM_W),
        .VW (CNT_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (sum_upd),
        .divisor   (n_eff),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (under) begin
                    state_next = fe_reg ? ST_EMIT : ST_IDLE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready   = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        emit_fire = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_LOAD: begin
                ram_we    = 1'b1;
                div_start = !under;
            end
            ST_EMIT: emit_fire = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign in_acc    = s_valid && s_ready;
    assign emit_last = (idx_reg == total_reg - 1'b1);
    assign emit_done = emit_fire && emit_last;
    assign emit_val  = short_reg ? '0
                     : (mid_reg && (idx_reg == head_reg)) ? fl_reg : rnd_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wlen_reg    <= CFG_W'(1);
            ptr_reg     <= '0;
            filled_reg  <= '0;
            sum_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                wlen_reg   <= cfg_window_length;
                filled_reg <= '0;
                sum_reg    <= '0;
            end else if (state_reg == ST_LOAD) begin
                ptr_reg    <= (ptr_reg == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
                filled_reg <= fe_reg ? '0 : filled_upd;
                sum_reg    <= fe_reg ? '0 : sum_upd;
            end
            if (emit_fire) begin
                idx_reg <= emit_last ? '0 : idx_reg + 1'b1;
            end
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            smp_reg  <= s_sample[SAMPLE_BITS-1:0];
            fe_reg   <= s_frame_end;
            full_reg <= (filled_reg >= n_eff);
        end
        if (state_reg == ST_LOAD) begin
            short_reg <= under;
            total_reg <= under ? CNT_W'(1) : total_cnt;
            head_reg  <= head_cnt;
            mid_reg   <= !fe_reg || n_eff[0];
        end
        if (div_done) begin
            fl_reg  <= SAMPLE_BITS'(div_q);
            rnd_reg <= SAMPLE_BITS'(div_q + SUM_W'({div_r, 1'b0} >= EW'(n_eff)));
        end
        if (emit_fire) begin
            m_smoothed_reg <= DATA_W'(emit_val);
            m_last_reg     <= fe_reg && emit_last;
            m_short_reg    <= short_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_smoothed    = m_smoothed_reg;
    assign m_last_out    = m_last_reg;
    assign m_short_frame = m_short_reg;

endmodule

// ----- src/cma_checker.sv -----
// Port-level checks for the centered moving average unit, with bind.
module cma_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [cma_pkg::DATA_W-1:0] m_smoothed,
    input logic                       m_last_out,
    input logic                       m_short_frame
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_smoothed) && $stable(m_last_out))
        else $error("result word changed while stalled");

    a_short_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_short_frame |-> m_last_out && (m_smoothed == '0))
        else $error("short frame word not last or not zero");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while previous word in progress");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind centered_moving_average_unit cma_checker u_cma_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_smoothed    (m_smoothed),
    .m_last_out    (m_last_out),
    .m_short_frame (m_short_frame)
);
